/* hw/rtl/bgl_pkg.sv */
// Shared types and constants for the gradient line generator.
// Used by bgl_div, bresenham_gradient_line, bgl_pixel_checker and testbench; no dependencies.
`timescale 1ns / 1ps

package bgl_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int COLOR_BITS = 8;
  localparam int NUM_CH     = 3;
  localparam int CH_W       = 2;

  // color accumulator: unsigned Q8.FRAC, slope: signed Q8.FRAC plus sign
  localparam int ACC_W   = COLOR_BITS + FRAC_BITS;
  localparam int SLOPE_W = ACC_W + 1;

  // divider: color delta << FRAC over the major span
  localparam int NUM_W = COLOR_BITS + FRAC_BITS;
  localparam int REM_W = COORD_BITS + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam int ERR_W = COORD_BITS + 1;

  localparam int IN_DATA_W  = 4 * COORD_BITS + 2 * NUM_CH * COLOR_BITS;
  localparam int OUT_DATA_W = 2 * COORD_BITS + NUM_CH * COLOR_BITS;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [NUM_W-1:0]      num;
    logic [COORD_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

/* hw/rtl/bgl_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Shared by the three color slope computations. Depends on bgl_pkg.
`timescale 1ns / 1ps

module bgl_div (
  input  logic              clk,
  input  logic              rst,
  input  bgl_pkg::div_req_t req,
  output bgl_pkg::div_rsp_t rsp
);

  logic                           busy;
  logic                           done;
  logic [bgl_pkg::CNT_W-1:0]      cnt;
  logic [bgl_pkg::REM_W-1:0]      rem;
  logic [bgl_pkg::REM_W-1:0]      rem_next;
  logic [bgl_pkg::NUM_W-1:0]      quo;
  logic [bgl_pkg::COORD_BITS-1:0] den;
  logic [bgl_pkg::REM_W-1:0]      rem_sh;
  logic [bgl_pkg::REM_W:0]        trial;
  logic                           q_bit;

  always_comb begin
    rem_sh   = {rem[bgl_pkg::REM_W-2:0], quo[bgl_pkg::NUM_W-1]};
    trial    = {1'b0, rem_sh} - {2'b00, den};
    q_bit    = ~trial[bgl_pkg::REM_W];
    rem_next = q_bit ? trial[bgl_pkg::REM_W-1:0] : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= bgl_pkg::CNT_W'(bgl_pkg::NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == bgl_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[bgl_pkg::NUM_W-2:0], q_bit};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

/* hw/rtl/bresenham_gradient_line.sv */
// Bresenham line stepper with per-channel linear color interpolation.
// A step transaction yields its pixel on m_tdata in the cycle after acceptance.
// Throughput: one pixel per cycle while m_tready stays high.
// A start transaction with a nonzero major span holds s_tready low while
// the shared one-bit-per-cycle slope divider runs once for each of the 3 channels.
// Synchronous active-high rst: idle, no line in progress, output empty.
`timescale 1ns / 1ps

module bresenham_gradient_line (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // start_x, start_y, end_x, end_y, start_red, start_green, start_blue,
  // end_red, end_green, end_blue
  input  logic [bgl_pkg::IN_DATA_W-1:0]  s_tdata,
  // op
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // pixel_x, pixel_y, red, green, blue
  output logic [bgl_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast
);

  localparam int CB = 4 * bgl_pkg::COORD_BITS;
  localparam int CE = CB + bgl_pkg::NUM_CH * bgl_pkg::COLOR_BITS;

  bgl_pkg::state_t   state, state_next;
  bgl_pkg::div_req_t div_req;
  bgl_pkg::div_rsp_t div_rsp;

  logic in_acc, is_start, is_step;

  // line state
  logic                                active;
  logic                                steep_flag;
  logic [bgl_pkg::COORD_BITS-1:0]      major_pos, major_end, minor_pos;
  logic                                minor_down;
  logic [bgl_pkg::COORD_BITS-1:0]      major_span, minor_span;
  logic signed [bgl_pkg::ERR_W-1:0]    error_term;
  logic [bgl_pkg::ACC_W-1:0]           color_accum [bgl_pkg::NUM_CH];
  logic [bgl_pkg::SLOPE_W-1:0]         color_slope [bgl_pkg::NUM_CH];
  logic [bgl_pkg::COLOR_BITS-1:0]      col_near    [bgl_pkg::NUM_CH];
  logic [bgl_pkg::COLOR_BITS-1:0]      col_far     [bgl_pkg::NUM_CH];
  logic [bgl_pkg::CH_W-1:0]            ch;
  logic                                div_neg;

  // setup
  logic [bgl_pkg::COORD_BITS-1:0] sx, sy, ex, ey, adx, ady;
  logic [bgl_pkg::COORD_BITS-1:0] amaj0, amin0, bmaj0, bmin0;
  logic [bgl_pkg::COORD_BITS-1:0] amaj, amin, bmaj, bmin;
  logic [bgl_pkg::COORD_BITS-1:0] span_in, mspan_in;
  logic [bgl_pkg::COLOR_BITS-1:0] in_ca [bgl_pkg::NUM_CH];
  logic [bgl_pkg::COLOR_BITS-1:0] in_cb [bgl_pkg::NUM_CH];
  logic                           steep_in, swap_in;

  // divider operand
  logic [bgl_pkg::COLOR_BITS:0]   cdiff;
  logic [bgl_pkg::COLOR_BITS-1:0] cmag;

  // stepping
  logic                           last_pix;
  logic signed [bgl_pkg::ERR_W-1:0] err_sub;
  logic [bgl_pkg::COORD_BITS-1:0] px, py;

  always_comb begin
    sx = s_tdata[bgl_pkg::COORD_BITS-1:0];
    sy = s_tdata[2*bgl_pkg::COORD_BITS-1 -: bgl_pkg::COORD_BITS];
    ex = s_tdata[3*bgl_pkg::COORD_BITS-1 -: bgl_pkg::COORD_BITS];
    ey = s_tdata[4*bgl_pkg::COORD_BITS-1 -: bgl_pkg::COORD_BITS];
    for (int i = 0; i < bgl_pkg::NUM_CH; i++) begin
      in_ca[i] = s_tdata[CB + i*bgl_pkg::COLOR_BITS +: bgl_pkg::COLOR_BITS];
      in_cb[i] = s_tdata[CE + i*bgl_pkg::COLOR_BITS +: bgl_pkg::COLOR_BITS];
    end
    adx      = (sx > ex) ? sx - ex : ex - sx;
    ady      = (sy > ey) ? sy - ey : ey - sy;
    steep_in = ady > adx;
    amaj0    = steep_in ? sy : sx;
    amin0    = steep_in ? sx : sy;
    bmaj0    = steep_in ? ey : ex;
    bmin0    = steep_in ? ex : ey;
    swap_in  = amaj0 > bmaj0;
    amaj     = swap_in ? bmaj0 : amaj0;
    amin     = swap_in ? bmin0 : amin0;
    bmaj     = swap_in ? amaj0 : bmaj0;
    bmin     = swap_in ? amin0 : bmin0;
    span_in  = bmaj - amaj;
    mspan_in = (amin > bmin) ? amin - bmin : bmin - amin;
  end

  always_comb begin
    cdiff = {1'b0, col_far[ch]} - {1'b0, col_near[ch]};
    cmag  = cdiff[bgl_pkg::COLOR_BITS] ? bgl_pkg::COLOR_BITS'(-cdiff)
                                       : cdiff[bgl_pkg::COLOR_BITS-1:0];
  end

  always_comb begin
    last_pix = bgl_pkg::COORD_BITS'(major_pos + 1'b1) == major_end;
    err_sub  = error_term - $signed({1'b0, minor_span});
    px       = steep_flag ? minor_pos : major_pos;
    py       = steep_flag ? major_pos : minor_pos;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= bgl_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = {cmag, {bgl_pkg::FRAC_BITS{1'b0}}};
    div_req.den   = major_span;
    unique case (state)
      bgl_pkg::ST_IDLE: begin
        s_tready = !m_tvalid || m_tready;
        if (s_tvalid && s_tready && s_tuser == bgl_pkg::OP_START && span_in != '0)
          state_next = bgl_pkg::ST_LAUNCH;
      end
      bgl_pkg::ST_LAUNCH: begin
        div_req.start = 1'b1;
        state_next    = bgl_pkg::ST_WAIT;
      end
      bgl_pkg::ST_WAIT: begin
        if (div_rsp.done)
          state_next = (ch == bgl_pkg::CH_W'(bgl_pkg::NUM_CH - 1)) ? bgl_pkg::ST_IDLE
                                                                   : bgl_pkg::ST_LAUNCH;
      end
      default: state_next = bgl_pkg::ST_IDLE;
    endcase
  end

  assign in_acc   = s_tvalid && s_tready;
  assign is_start = in_acc && s_tuser == bgl_pkg::OP_START;
  assign is_step  = in_acc && s_tuser == bgl_pkg::OP_STEP && active;

  bgl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      m_tvalid <= 1'b0;
      ch       <= '0;
    end else begin
      if (is_step) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (is_start) begin
        active <= span_in != '0;
        ch     <= '0;
      end else if (is_step && last_pix) begin
        active <= 1'b0;
      end
      if (state == bgl_pkg::ST_WAIT && div_rsp.done) ch <= ch + 1'b1;
    end
  end

  // line datapath
  always_ff @(posedge clk) begin
    if (is_start) begin
      steep_flag <= steep_in;
      major_pos  <= amaj;
      major_end  <= bmaj;
      minor_pos  <= amin;
      major_span <= span_in;
      minor_span <= mspan_in;
      minor_down <= !(amin < bmin);
      error_term <= $signed({1'b0, span_in >> 1});
      for (int i = 0; i < bgl_pkg::NUM_CH; i++) begin
        col_near[i]    <= swap_in ? in_cb[i] : in_ca[i];
        col_far[i]     <= swap_in ? in_ca[i] : in_cb[i];
        color_accum[i] <= {swap_in ? in_cb[i] : in_ca[i], {bgl_pkg::FRAC_BITS{1'b0}}};
        color_slope[i] <= '0;
      end
    end else if (is_step) begin
      m_tdata <= {color_accum[2][bgl_pkg::ACC_W-1 -: bgl_pkg::COLOR_BITS],
                  color_accum[1][bgl_pkg::ACC_W-1 -: bgl_pkg::COLOR_BITS],
                  color_accum[0][bgl_pkg::ACC_W-1 -: bgl_pkg::COLOR_BITS],
                  py, px};
      m_tlast <= last_pix;
      if (err_sub[bgl_pkg::ERR_W-1]) begin
        minor_pos  <= minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
        error_term <= err_sub + $signed({1'b0, major_span});
      end else begin
        error_term <= err_sub;
      end
      // accumulator stays inside the endpoint colors, so wrap never occurs
      for (int i = 0; i < bgl_pkg::NUM_CH; i++)
        color_accum[i] <= color_accum[i] + color_slope[i][bgl_pkg::ACC_W-1:0];
      major_pos <= major_pos + 1'b1;
    end
    if (state == bgl_pkg::ST_LAUNCH)
      div_neg <= cdiff[bgl_pkg::COLOR_BITS];
    if (state == bgl_pkg::ST_WAIT && div_rsp.done)
      color_slope[ch] <= div_neg ? bgl_pkg::SLOPE_W'(-{1'b0, div_rsp.quo})
                                 : {1'b0, div_rsp.quo};
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    active |-> major_pos < major_end)
    else $error("major position ran past the line end");

  a_err_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> (!error_term[bgl_pkg::ERR_W-1] &&
                error_term[bgl_pkg::COORD_BITS-1:0] < major_span))
    else $error("error term out of bounds");

  a_minor_le_major: assert property (@(posedge clk) disable iff (rst)
    active |-> minor_span <= major_span)
    else $error("minor span exceeds major span");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == bgl_pkg::ST_WAIT)
    else $error("divider finished outside wait state");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (is_step && last_pix) |=> (!active && m_tvalid && m_tlast))
    else $error("final pixel did not end the line");

endmodule

/* test/bgl_pixel_checker.sv */
// Checker for the gradient line generator: tracks the line state from accepted
// input transactions, predicts each pixel and compares it with the output stream.
// Depends on bgl_pkg for field widths and the op encoding.
`timescale 1ns / 1ps

module bgl_pixel_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [bgl_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [bgl_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           m_tlast,
  output int                             fail_count,
  output int                             pending
);

  import bgl_pkg::*;

  localparam int COORD_MASK = (1 << COORD_BITS) - 1;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic                  last;
  } pixel_t;

  pixel_t expected_pixels[$];

  // line tracker state
  logic   line_live;
  logic   steep;
  logic   min_down;
  int     maj_pos, maj_end, min_pos, maj_span, min_span, err;
  longint accum[NUM_CH];
  longint slope[NUM_CH];

  task automatic flag(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [COLOR_BITS-1:0] shade(input longint acc);
    longint v;
    if (acc < 0) return '0;
    v = acc >>> FRAC_BITS;
    return (v > 255) ? 8'd255 : v[COLOR_BITS-1:0];
  endfunction

  task automatic load_line(input logic [IN_DATA_W-1:0] d);
    int ax, ay, bx, by, adx, ady, amaj, amin, bmaj, bmin, t, i;
    int ca[NUM_CH];
    int cb[NUM_CH];
    ax = int'(d[0 +: COORD_BITS]);
    ay = int'(d[COORD_BITS +: COORD_BITS]);
    bx = int'(d[2*COORD_BITS +: COORD_BITS]);
    by = int'(d[3*COORD_BITS +: COORD_BITS]);
    for (i = 0; i < NUM_CH; i++) begin
      ca[i] = int'(d[4*COORD_BITS + i*COLOR_BITS +: COLOR_BITS]);
      cb[i] = int'(d[4*COORD_BITS + (NUM_CH+i)*COLOR_BITS +: COLOR_BITS]);
    end
    adx = (ax > bx) ? ax - bx : bx - ax;
    ady = (ay > by) ? ay - by : by - ay;
    steep = ady > adx;
    if (steep) begin
      amaj = ay; amin = ax; bmaj = by; bmin = bx;
    end else begin
      amaj = ax; amin = ay; bmaj = bx; bmin = by;
    end
    // order along the major axis, colors follow their endpoints
    if (amaj > bmaj) begin
      t = amaj; amaj = bmaj; bmaj = t;
      t = amin; amin = bmin; bmin = t;
      for (i = 0; i < NUM_CH; i++) begin
        t = ca[i]; ca[i] = cb[i]; cb[i] = t;
      end
    end
    maj_pos  = amaj;
    maj_end  = bmaj;
    min_pos  = amin;
    maj_span = bmaj - amaj;
    min_span = (amin > bmin) ? amin - bmin : bmin - amin;
    min_down = !(amin < bmin);
    err      = maj_span / 2;
    for (i = 0; i < NUM_CH; i++) begin
      accum[i] = longint'(ca[i]) <<< FRAC_BITS;
      // signed division truncates toward zero
      if (maj_span != 0)
        slope[i] = (longint'(cb[i] - ca[i]) * (longint'(1) <<< FRAC_BITS))
                   / longint'(maj_span);
      else
        slope[i] = 0;
    end
    line_live = maj_span != 0;
  endtask

  task automatic trace_pixel();
    pixel_t p;
    int     i;
    if (!line_live) return;
    p.x     = steep ? min_pos[COORD_BITS-1:0] : maj_pos[COORD_BITS-1:0];
    p.y     = steep ? maj_pos[COORD_BITS-1:0] : min_pos[COORD_BITS-1:0];
    p.red   = shade(accum[0]);
    p.green = shade(accum[1]);
    p.blue  = shade(accum[2]);
    p.last  = (maj_pos + 1 == maj_end);
    expected_pixels.push_back(p);
    err -= min_span;
    if (err < 0) begin
      min_pos = (min_down ? min_pos - 1 : min_pos + 1) & COORD_MASK;
      err += maj_span;
    end
    for (i = 0; i < NUM_CH; i++)
      accum[i] += slope[i];
    maj_pos = (maj_pos + 1) & COORD_MASK;
    if (maj_pos == maj_end) line_live = 1'b0;
  endtask

  task automatic check_pixel();
    pixel_t got, want;
    got.x     = m_tdata[0 +: COORD_BITS];
    got.y     = m_tdata[COORD_BITS +: COORD_BITS];
    got.red   = m_tdata[2*COORD_BITS +: COLOR_BITS];
    got.green = m_tdata[2*COORD_BITS + COLOR_BITS +: COLOR_BITS];
    got.blue  = m_tdata[2*COORD_BITS + 2*COLOR_BITS +: COLOR_BITS];
    got.last  = m_tlast;
    if (expected_pixels.size() == 0) begin
      flag($sformatf("pixel (%0d,%0d) with none expected", got.x, got.y));
      return;
    end
    want = expected_pixels.pop_front();
    if (got.x !== want.x) flag($sformatf("pixel_x %0d, want %0d", got.x, want.x));
    if (got.y !== want.y) flag($sformatf("pixel_y %0d, want %0d", got.y, want.y));
    if (got.red !== want.red) flag($sformatf("red %0d, want %0d", got.red, want.red));
    if (got.green !== want.green)
      flag($sformatf("green %0d, want %0d", got.green, want.green));
    if (got.blue !== want.blue) flag($sformatf("blue %0d, want %0d", got.blue, want.blue));
    if (got.last !== want.last) flag($sformatf("last %0b, want %0b", got.last, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fail_count = 0;
      line_live  = 1'b0;
      steep      = 1'b0;
      min_down   = 1'b0;
      maj_pos    = 0;
      maj_end    = 0;
      min_pos    = 0;
      maj_span   = 0;
      min_span   = 0;
      err        = 0;
      for (int i = 0; i < NUM_CH; i++) begin
        accum[i] = 0;
        slope[i] = 0;
      end
      expected_pixels.delete();
    end else begin
      // a pixel leaves no earlier than the cycle after its step, so compare first
      if (m_tvalid && m_tready) check_pixel();
      if (s_tvalid && s_tready) begin
        if (op_t'(s_tuser) == OP_START) load_line(s_tdata);
        else trace_pixel();
      end
    end
    pending = expected_pixels.size();
  end

endmodule

/* test/testbench.sv */
// Top of the gradient line generator test: clock, reset, stimulus and verdict.
// Depends on bgl_pkg, bresenham_gradient_line and bgl_pixel_checker.
`timescale 1ns / 1ps

module testbench;

  import bgl_pkg::*;

  localparam int TARGET_ITEMS = 550;
  localparam int STALL_LIMIT  = 2000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  int                    fail_count;
  int                    pending;

  int items_sent;
  int burst_left;
  int idle_cycles;
  int rx_mode, rx_left, rx_tick;

  bresenham_gradient_line dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  bgl_pixel_checker pixel_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: ready pattern switches among free flow, periodic and random stalls
  initial begin
    rx_mode = 0;
    rx_left = 0;
    rx_tick = 0;
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(32, 200);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= (rx_tick % 3) != 0;
      end
      2: begin
        m_tready <= $urandom_range(0, 3) != 0;
      end
      default: begin
        m_tready <= (rx_tick % 16) >= 10;
      end
    endcase
  end

  // watchdog: no transaction on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [IN_DATA_W-1:0] noise_word();
    return {$urandom, $urandom, $urandom};
  endfunction

  task automatic send(input op_t op, input logic [IN_DATA_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tdata  <= noise_word();
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // colors packed {blue, green, red}
  task automatic start_line(input logic [COORD_BITS-1:0] x0, input logic [COORD_BITS-1:0] y0,
                            input logic [COORD_BITS-1:0] x1, input logic [COORD_BITS-1:0] y1,
                            input logic [23:0] c0, input logic [23:0] c1);
    send(OP_START, {c1, c0, y1, x1, y0, x0});
  endtask

  task automatic step_pixels(input int n);
    repeat (n) send(OP_STEP, noise_word());
  endtask

  // place a span of length d on one axis, in a random direction
  task automatic lay_axis(input int d, output logic [COORD_BITS-1:0] p0,
                          output logic [COORD_BITS-1:0] p1);
    int a;
    if ($urandom_range(0, 1) != 0) begin
      a  = $urandom_range(d, 4095);
      p0 = COORD_BITS'(a);
      p1 = COORD_BITS'(a - d);
    end else begin
      a  = $urandom_range(0, 4095 - d);
      p0 = COORD_BITS'(a);
      p1 = COORD_BITS'(a + d);
    end
  endtask

  function automatic logic [23:0] pick_color();
    logic [23:0] c;
    c = 24'($urandom);
    if ($urandom_range(0, 3) == 0)
      for (int i = 0; i < 3; i++) c[8*i +: 8] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return c;
  endfunction

  task automatic random_line();
    int r, maj, mn, steps;
    logic [COORD_BITS-1:0] x0, y0, x1, y1;
    logic [23:0] c0, c1;
    r = $urandom_range(0, 9);
    maj = (r < 7) ? $urandom_range(0, 16) : (r < 9) ? $urandom_range(17, 64)
                                                     : $urandom_range(65, 4095);
    mn = $urandom_range(0, maj);
    if ($urandom_range(0, 1) != 0) begin
      lay_axis(mn, x0, x1);
      lay_axis(maj, y0, y1);
    end else begin
      lay_axis(maj, x0, x1);
      lay_axis(mn, y0, y1);
    end
    c0 = pick_color();
    c1 = ($urandom_range(0, 5) == 0) ? c0 : pick_color();
    start_line(x0, y0, x1, y1, c0, c1);
    if (maj > 64) steps = $urandom_range(0, 40);
    else if ($urandom_range(0, 5) == 0) steps = $urandom_range(0, maj);
    else steps = maj + $urandom_range(0, 2);
    step_pixels(steps);
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = OP_START;
    m_tready    = 1'b0;
    items_sent  = 0;
    burst_left  = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // step with no line in progress
    step_pixels(1);
    // zero-length line emits nothing
    start_line(12'd100, 12'd200, 12'd100, 12'd200, 24'h123456, 24'hABCDEF);
    step_pixels(1);
    // flat line, full color ramps, one step past the end
    start_line(12'd0, 12'd0, 12'd3, 12'd0, 24'h8000FF, 24'h80FF00);
    step_pixels(4);
    // steep line given back to front, top corner
    start_line(12'd4095, 12'd4095, 12'd4093, 12'd4090, 24'hFFFFFF, 24'h000000);
    step_pixels(6);
    // full-screen diagonal going down, abandoned by the next start
    start_line(12'd0, 12'd4095, 12'd4095, 12'd0, 24'h000000, 24'hFFFFFF);
    step_pixels(3);
    start_line(12'd10, 12'd10, 12'd12, 12'd13, 24'h00FF7F, 24'hFF0080);
    step_pixels(3);

    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send(op_t'($urandom_range(0, 1)), noise_word());
        step_pixels($urandom_range(0, 8));
      end else begin
        random_line();
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
